### rtl/plt_pkg.sv
package plt_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_REMOVE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic walk_busy;
    } t_ctl_stat;

endpackage

### rtl/plt_ctrl.sv
module plt_ctrl
    import plt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  logic      i_m_tready,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SETUP;
            end
            S_SETUP: n_state = S_RUN;
            S_RUN: begin
                if (i_stat.walk_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_SETUP: o_cmd.start = 1'b1;
            S_RUN:   o_cmd.step  = 1'b1;
            S_FINISH: begin
                o_cmd.finish = w_out_free;
                if (w_out_free) n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result appeared outside finish");

    a_idle_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.walk_busy)
        else $error("walk still active while idle");

    a_finish_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished command did not post its result");

endmodule

### rtl/plt_dpath.sv
module plt_dpath
    import plt_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    output t_ctl_stat          o_stat,
    input  logic [CMD_W-1:0]   i_cmd_code,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_status,
    output logic [VALUE_W-1:0] o_read_value,
    output logic [POS_W-1:0]   o_found_position,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    t_op                   r_op;
    logic [POS_W-1:0]      r_pos;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_addr;
    logic [CW-1:0]         r_left;
    logic                  r_up;
    logic                  r_pv;
    logic [AW-1:0]         r_paddr;
    logic [ELEM_WIDTH-1:0] r_rdata;
    logic [CW-1:0]         r_wptr;
    logic                  r_ok;
    logic [AW-1:0]         r_fpos;
    logic [ELEM_WIDTH-1:0] r_rd;

    logic [XW-1:0] w_pos_x, w_cnt_x, w_depth_x;
    logic          w_issue;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [ELEM_WIDTH-1:0] w_wdata;
    logic          w_match;
    logic signed [63:0] w_wide;

    assign w_pos_x   = XW'(r_pos);
    assign w_cnt_x   = XW'(r_count);
    assign w_depth_x = XW'(DEPTH);
    assign w_issue   = i_cmd.step && (r_left != '0);
    assign w_match   = (r_rdata == r_val);

    assign o_stat.walk_done = (r_left == '0) && !r_pv;
    assign o_stat.walk_busy = (r_left != '0) || r_pv;

    // one write port: shifted or compacted entries during the walk, the new value at finish
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_paddr;
        w_wdata = r_rdata;
        if (r_pv) begin
            case (r_op)
                OP_INSERT: begin
                    w_we    = 1'b1;
                    w_waddr = r_paddr + AW'(1);
                end
                OP_DELETE: begin
                    w_we    = 1'b1;
                    w_waddr = r_paddr - AW'(1);
                end
                OP_REMOVE: begin
                    w_we    = !w_match;
                    w_waddr = r_wptr[AW-1:0];
                end
                default: w_we = 1'b0;
            endcase
        end else if (i_cmd.finish && r_op == OP_INSERT && r_ok) begin
            w_we    = 1'b1;
            w_waddr = w_pos_x[AW-1:0];
            w_wdata = r_val;
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_ok) begin
            case (r_op)
                OP_INSERT: n_count = r_count + CW'(1);
                OP_DELETE: n_count = r_count - CW'(1);
                OP_REMOVE: n_count = r_wptr;
                default:   n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_issue) r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_cmd_code);
            r_pos <= i_position;
            r_val <= ELEM_WIDTH'(i_value);
        end
        if (i_cmd.start) begin
            r_wptr <= '0;
            r_rd   <= '0;
            r_fpos <= '0;
            case (r_op)
                OP_GET: begin
                    r_ok   <= w_pos_x < w_cnt_x;
                    r_up   <= 1'b1;
                    r_addr <= w_pos_x[AW-1:0];
                end
                OP_LOCATE: begin
                    r_ok   <= 1'b0;
                    r_up   <= 1'b1;
                    r_addr <= '0;
                end
                OP_INSERT: begin
                    r_ok   <= (w_pos_x <= w_cnt_x) && (w_cnt_x < w_depth_x);
                    r_up   <= 1'b0;
                    r_addr <= AW'(w_cnt_x - XW'(1));
                end
                OP_DELETE: begin
                    r_ok   <= w_pos_x < w_cnt_x;
                    r_up   <= 1'b1;
                    r_addr <= AW'(w_pos_x + XW'(1));
                end
                OP_REMOVE: begin
                    r_ok   <= 1'b1;
                    r_up   <= 1'b1;
                    r_addr <= '0;
                end
                default: begin
                    r_ok   <= 1'b0;
                    r_up   <= 1'b1;
                    r_addr <= '0;
                end
            endcase
        end
        if (w_issue) begin
            r_paddr <= r_addr;
            r_addr  <= r_up ? r_addr + AW'(1) : r_addr - AW'(1);
        end
        if (r_pv) begin
            case (r_op)
                OP_GET: r_rd <= r_rdata;
                OP_LOCATE: begin
                    if (!r_ok && w_match) begin
                        r_ok   <= 1'b1;
                        r_fpos <= r_paddr;
                    end
                end
                OP_REMOVE: begin
                    if (!w_match) r_wptr <= r_wptr + CW'(1);
                end
                default: r_rd <= r_rd;
            endcase
        end
        if (i_cmd.finish) begin
            o_status         <= !r_ok;
            o_read_value     <= (r_op == OP_GET && r_ok) ? w_wide[VALUE_W-1:0] : '0;
            o_found_position <= (r_op == OP_LOCATE && r_ok) ? POS_W'(r_fpos) : '0;
            o_entry_count    <= COUNT_W'(n_count);
        end
    end

    assign w_wide = 64'($signed(r_rd));

    // control state of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (i_cmd.start) begin
                case (r_op)
                    OP_GET:    r_left <= (w_pos_x < w_cnt_x) ? CW'(1) : '0;
                    OP_LOCATE: r_left <= r_count;
                    OP_INSERT: r_left <= ((w_pos_x <= w_cnt_x) && (w_cnt_x < w_depth_x))
                                         ? CW'(w_cnt_x - w_pos_x) : '0;
                    OP_DELETE: r_left <= (w_pos_x < w_cnt_x)
                                         ? CW'(w_cnt_x - w_pos_x - XW'(1)) : '0;
                    OP_REMOVE: r_left <= r_count;
                    default:   r_left <= '0;
                endcase
            end else if (w_issue) begin
                r_left <= r_left - CW'(1);
            end
            if (i_cmd.finish) r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= w_depth_x)
        else $error("fill count beyond depth");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && r_op == OP_REMOVE) |-> (r_wptr <= CW'(r_paddr)))
        else $error("remove-all write pointer passed read pointer");

    a_no_write_at_finish_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_pv && (r_left == '0))
        else $error("finish while walk still in flight");

endmodule

### rtl/positional_list_table.sv
// positional list table: ordered list of up to DEPTH signed words with a fill count
// slave channel (s_axis): one command per transaction, tdata holds cmd, position, value
//   cmd: get, locate, insert, delete at position, remove all equal to value
// master channel (m_axis): exactly one result transaction per command, tdata holds
//   status, read_value, found_position, entry_count
// one command at a time; a command walks the list through a memory with one read
//   and one write port, one entry per cycle
// s_tready returns in the cycle the result is posted, so the sustained rate
//   is set by the entry walk
// the result sits in an output register; s_tready returns while it waits, and a
//   following command runs its walk and then holds until m_tready frees the register
// reset (synchronous, active low) empties the list; the memory keeps no valid bits,
//   entries past the fill count are never read
module positional_list_table
    import plt_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // cmd[2:0], position[9:3], value[41:10]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // status[0], read_value[32:1],
                                                // found_position[39:33], entry_count[47:40]
);

    t_ctl_cmd  w_cmd;
    t_ctl_stat w_stat;

    logic               w_status;
    logic [VALUE_W-1:0] w_read_value;
    logic [POS_W-1:0]   w_found_position;
    logic [COUNT_W-1:0] w_entry_count;

    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    plt_dpath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cmd_code       (s_axis_tdata[CMD_W-1:0]),
        .i_position       (s_axis_tdata[CMD_W +: POS_W]),
        .i_value          (s_axis_tdata[CMD_W+POS_W +: VALUE_W]),
        .o_status         (w_status),
        .o_read_value     (w_read_value),
        .o_found_position (w_found_position),
        .o_entry_count    (w_entry_count)
    );

    assign m_axis_tdata = {w_entry_count, w_found_position, w_read_value, w_status};

endmodule

### bench/tb_positional_list_table.sv
`timescale 1ns / 100ps

module tb_positional_list_table;
    import plt_pkg::*;

    localparam int LIST_DEPTH   = 128;
    localparam int PAD_W        = S_TDATA_W - CMD_W - POS_W - VALUE_W;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TARGET_ITEMS = 550;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    localparam logic [VALUE_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] WORD_ZERO = 32'h0000_0000;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } list_cmd_t;

    typedef struct {
        logic               status;
        logic [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]   found_pos;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // cmd, position, value, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // status, read_value, found_position, entry_count

    positional_list_table #(
        .DEPTH      (LIST_DEPTH),
        .ELEM_WIDTH (VALUE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the list, updated as each command transaction is accepted
    logic [VALUE_W-1:0] list_words [LIST_DEPTH];
    int                 list_count = 0;

    list_cmd_t    cmd_backlog[$];
    list_result_t predicted_results[$];
    list_cmd_t    cur_cmd;
    int           items_sent     = 0;
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           gap_left       = 0;
    int           burst_left     = 1;
    int           stall_mode     = 0;
    int           stall_left     = 0;

    logic [VALUE_W-1:0] value_pool [8];

    function automatic list_result_t apply_list_command(list_cmd_t c);
        list_result_t r;
        int           j;
        int           k;
        logic         hit;
        r.status     = ST_REFUSED;
        r.read_value = '0;
        r.found_pos  = '0;
        hit          = 1'b0;
        case (c.cmd)
            OP_GET: begin
                if (int'(c.pos) < list_count) begin
                    r.read_value = list_words[c.pos];
                    r.status     = ST_OK;
                end
            end
            OP_LOCATE: begin
                for (j = 0; j < list_count && !hit; j++) begin
                    if (list_words[j] == c.value) begin
                        r.found_pos = POS_W'(j);
                        r.status    = ST_OK;
                        hit         = 1'b1;
                    end
                end
            end
            OP_INSERT: begin
                if (int'(c.pos) <= list_count && list_count < LIST_DEPTH) begin
                    for (j = list_count; j > int'(c.pos); j--)
                        list_words[j] = list_words[j-1];
                    list_words[c.pos] = c.value;
                    list_count++;
                    r.status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (int'(c.pos) < list_count) begin
                    for (j = int'(c.pos); j + 1 < list_count; j++)
                        list_words[j] = list_words[j+1];
                    list_count--;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                k = 0;
                for (j = 0; j < list_count; j++) begin
                    if (list_words[j] != c.value) begin
                        list_words[k] = list_words[j];
                        k++;
                    end
                end
                list_count = k;
                r.status   = ST_OK;
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        list_result_t want;
        if (predicted_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", 64'(word), '0);
            return;
        end
        want = predicted_results.pop_front();
        if (word[0] !== want.status)
            report_mismatch("status", 64'(word[0]), 64'(want.status));
        if (word[32:1] !== want.read_value)
            report_mismatch("read_value", 64'(word[32:1]), 64'(want.read_value));
        if (word[39:33] !== want.found_pos)
            report_mismatch("found_position", 64'(word[39:33]), 64'(want.found_pos));
        if (word[47:40] !== want.count)
            report_mismatch("entry_count", 64'(word[47:40]), 64'(want.count));
    endtask

    // command driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
            burst_left    <= 1;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_results.push_back(apply_list_command(cur_cmd));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_axis_tdata  <= {{PAD_W{1'b0}}, cur_cmd.value, cur_cmd.pos, cur_cmd.cmd};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(8, 60);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value);
        list_cmd_t c;
        while (cmd_backlog.size() >= 2)
            @(negedge i_clk);
        c.cmd   = op;
        c.pos   = pos;
        c.value = value;
        cmd_backlog.push_back(c);
        items_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // mostly positions around the live range, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_pos();
        int top;
        top = (list_count > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : list_count;
        if ($urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, top));
        return POS_W'($urandom_range(0, LIST_DEPTH - 1));
    endfunction

    task automatic random_command(input int insert_pct, input int delete_pct);
        int               roll;
        logic [CMD_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            op = OP_INSERT;
        else if (roll < insert_pct + delete_pct)
            op = OP_DELETE;
        else if (roll < insert_pct + delete_pct + 20)
            op = OP_GET;
        else if (roll < insert_pct + delete_pct + 35)
            op = OP_LOCATE;
        else if (roll < 97)
            op = OP_REMOVE;
        else
            op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        push_cmd(op, pick_pos(), pick_value());
    endtask

    task automatic wait_list_idle();
        while (cmd_backlog.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int i;
        int top;
        value_pool[0] = WORD_ZERO;
        value_pool[1] = WORD_ONES;
        value_pool[2] = WORD_MIN;
        value_pool[3] = WORD_MAX;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'h5555_5555;
        value_pool[6] = 32'hAAAA_AAAA;
        value_pool[7] = $urandom();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list corner cases
        push_cmd(OP_GET,    7'd0,   WORD_ZERO);
        push_cmd(OP_LOCATE, 7'd0,   WORD_ZERO);
        push_cmd(OP_DELETE, 7'd0,   WORD_ZERO);
        push_cmd(OP_REMOVE, 7'd0,   WORD_ZERO);
        push_cmd(OP_INSERT, 7'd1,   WORD_MAX);
        // build a short list, appends and front inserts
        push_cmd(OP_INSERT, 7'd0,   WORD_MIN);
        push_cmd(OP_INSERT, 7'd1,   WORD_MAX);
        push_cmd(OP_INSERT, 7'd0,   WORD_ONES);
        push_cmd(OP_INSERT, 7'd1,   WORD_ZERO);
        push_cmd(OP_GET,    7'd0,   WORD_ZERO);
        push_cmd(OP_GET,    7'd3,   WORD_ZERO);
        push_cmd(OP_GET,    7'd4,   WORD_ZERO);
        push_cmd(OP_GET,    7'd127, WORD_ONES);
        push_cmd(OP_LOCATE, 7'd0,   WORD_MAX);
        push_cmd(OP_LOCATE, 7'd127, 32'h0012_3456);
        push_cmd(OP_INSERT, 7'd2,   WORD_ONES);
        push_cmd(OP_LOCATE, 7'd0,   WORD_ONES);
        push_cmd(OP_REMOVE, 7'd0,   WORD_ONES);
        push_cmd(OP_REMOVE, 7'd0,   32'h0BAD_0BAD);
        push_cmd(OP_DELETE, 7'd127, WORD_ZERO);
        push_cmd(OP_DELETE, 7'd0,   WORD_ZERO);
        push_cmd(OP_DELETE, 7'd1,   WORD_ZERO);
        push_cmd(CMD_UNUSED_LO,  7'd127, WORD_ONES);
        push_cmd(CMD_UNUSED_MID, 7'd0,   WORD_MIN);
        push_cmd(CMD_UNUSED_HI,  7'd64,  WORD_MAX);

        for (i = 0; i < 150; i++)
            random_command(35, 15);

        // sender holds off until every outstanding result is back
        wait_list_idle();

        // fill the list to capacity
        for (i = 0; i < 220 && list_count < LIST_DEPTH; i++) begin
            top = (list_count > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : list_count;
            push_cmd(OP_INSERT, POS_W'($urandom_range(0, top)), pick_value());
        end
        wait_list_idle();
        push_cmd(OP_INSERT, 7'd0,   WORD_MAX);
        push_cmd(OP_INSERT, 7'd127, WORD_MIN);
        push_cmd(OP_GET,    7'd127, WORD_ZERO);
        push_cmd(OP_LOCATE, 7'd0,   value_pool[7]);
        push_cmd(OP_LOCATE, 7'd0,   32'h1357_9BDF);
        push_cmd(OP_DELETE, 7'd127, WORD_ZERO);
        push_cmd(OP_INSERT, 7'd127, WORD_ONES);
        push_cmd(OP_GET,    7'd127, WORD_ZERO);
        for (i = 0; i < 10; i++)
            random_command(30, 20);

        // drain with remove-all sweeps and deletes
        for (i = 0; i < 8; i++) begin
            push_cmd(OP_REMOVE, pick_pos(), value_pool[i]);
            push_cmd(OP_GET, pick_pos(), WORD_ZERO);
        end
        for (i = 0; i < 30; i++)
            random_command(10, 40);

        while (items_sent < TARGET_ITEMS)
            random_command(35, 15);

        wait_list_idle();
        repeat (LIST_DEPTH + 8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
